// ===== sv/cylinder_point_projection_defines.svh =====
// Assertion helpers for the projection block.
`ifndef CYLINDER_POINT_PROJECTION_DEFINES_SVH
`define CYLINDER_POINT_PROJECTION_DEFINES_SVH

// same-cycle implication
`define CPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cylinder_point_projection: check failed");

// next-cycle implication
`define CPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cylinder_point_projection: check failed");

`endif

// ===== sv/cpp_pkg.sv =====
`default_nettype none
package cpp_pkg;

  localparam int CW = 32;
  localparam int RW = CW - 1;
  localparam int PW = 2 * CW;

  localparam logic [RW-1:0] HALF_LENGTH_RST = 31'd65536;
  localparam logic [RW-1:0] RADIUS_RST      = 31'd65536;

  typedef enum logic {
    REG_HALF_LENGTH = 1'b0,
    REG_RADIUS      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_z;
  } cpp_in_t;

  typedef struct packed {
    logic                 inside_flag;
    logic signed [CW-1:0] proj_x;
    logic signed [CW-1:0] proj_y;
    logic signed [CW-1:0] proj_z;
  } cpp_out_t;

  typedef struct packed {
    logic          x_neg;
    logic          y_neg;
    logic          z_neg;
    logic          in_x;
    logic          in_yz;
    logic [CW-1:0] raw_x;
    logic [CW-1:0] raw_y;
    logic [CW-1:0] raw_z;
    logic [CW-1:0] xm;
    logic [CW-1:0] root;
    logic [CW-1:0] qy;
    logic [CW-1:0] qz;
    logic [PW-1:0] rem_sq;
    logic [PW-1:0] rem_y;
    logic [PW-1:0] rem_z;
  } cpp_tok_t;

  function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [CW-1:0] encode(input logic neg, input logic [CW-1:0] m);
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cpp_front.sv =====
`default_nettype none
module cpp_front import cpp_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [RW-1:0] half_length,
  input  wire logic [RW-1:0] radius,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpp_in_t       in_word,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cpp_tok_t           out_tok
);

  logic          a_v_r;
  logic          a_rdy;
  logic          xn_r, yn_r, zn_r, in_x_r;
  logic [CW-1:0] rx_r, ry_r, rz_r, xm_r;
  logic [PW-1:0] ysq_r, zsq_r, ynum_r, znum_r, rlim_r;

  logic [CW-1:0] xm_nxt, ym_nxt, zm_nxt, rad_w;
  logic [PW-1:0] ysq_nxt, zsq_nxt, ynum_nxt, znum_nxt, rlim_nxt, rsq_w;

  logic     b_v_r;
  cpp_tok_t tok_r;
  cpp_tok_t tok_nxt;

  assign rad_w    = {1'b0, radius};
  assign xm_nxt   = mag_of(in_word.coord_x);
  assign ym_nxt   = mag_of(in_word.coord_y);
  assign zm_nxt   = mag_of(in_word.coord_z);
  assign ysq_nxt  = ym_nxt * ym_nxt;
  assign zsq_nxt  = zm_nxt * zm_nxt;
  assign ynum_nxt = ym_nxt * rad_w;
  assign znum_nxt = zm_nxt * rad_w;
  assign rlim_nxt = rad_w * rad_w;

  assign a_rdy    = !b_v_r || out_ready;
  assign in_ready = !a_v_r || a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_ready) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      xn_r   <= in_word.coord_x[CW-1];
      yn_r   <= in_word.coord_y[CW-1];
      zn_r   <= in_word.coord_z[CW-1];
      in_x_r <= xm_nxt <= {1'b0, half_length};
      rx_r   <= in_word.coord_x;
      ry_r   <= in_word.coord_y;
      rz_r   <= in_word.coord_z;
      xm_r   <= xm_nxt;
      ysq_r  <= ysq_nxt;
      zsq_r  <= zsq_nxt;
      ynum_r <= ynum_nxt;
      znum_r <= znum_nxt;
      rlim_r <= rlim_nxt;
    end
  end

  assign rsq_w = ysq_r + zsq_r;

  always_comb begin
    tok_nxt        = '0;
    tok_nxt.x_neg  = xn_r;
    tok_nxt.y_neg  = yn_r;
    tok_nxt.z_neg  = zn_r;
    tok_nxt.in_x   = in_x_r;
    tok_nxt.in_yz  = rsq_w <= rlim_r;
    tok_nxt.raw_x  = rx_r;
    tok_nxt.raw_y  = ry_r;
    tok_nxt.raw_z  = rz_r;
    tok_nxt.xm     = xm_r;
    tok_nxt.rem_sq = rsq_w;
    tok_nxt.rem_y  = ynum_r;
    tok_nxt.rem_z  = znum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (a_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && a_v_r) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = b_v_r;
  assign out_tok   = tok_r;

endmodule
`default_nettype wire

// ===== sv/cpp_sqrt_cell.sv =====
`default_nettype none
module cpp_sqrt_cell import cpp_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire cpp_tok_t in_tok,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cpp_tok_t      out_tok
);

  logic          v_r;
  cpp_tok_t      tok_r;
  cpp_tok_t      tok_nxt;
  logic [PW:0]   trial;
  logic          take;

  assign trial = ((PW+1)'(in_tok.root) << (BIT + 1)) + ((PW+1)'(1) << (2 * BIT));
  assign take  = {1'b0, in_tok.rem_sq} >= trial;

  always_comb begin
    tok_nxt = in_tok;
    if (take) begin
      tok_nxt.rem_sq    = in_tok.rem_sq - trial[PW-1:0];
      tok_nxt.root[BIT] = 1'b1;
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_tok   = tok_r;

endmodule
`default_nettype wire

// ===== sv/cpp_div_cell.sv =====
`default_nettype none
module cpp_div_cell import cpp_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire cpp_tok_t in_tok,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cpp_tok_t      out_tok
);

  logic          v_r;
  cpp_tok_t      tok_r;
  cpp_tok_t      tok_nxt;
  logic [PW:0]   dvs;
  logic          take_y, take_z;

  assign dvs    = (PW+1)'(in_tok.root) << BIT;
  assign take_y = {1'b0, in_tok.rem_y} >= dvs;
  assign take_z = {1'b0, in_tok.rem_z} >= dvs;

  always_comb begin
    tok_nxt = in_tok;
    if (take_y) begin
      tok_nxt.rem_y   = in_tok.rem_y - dvs[PW-1:0];
      tok_nxt.qy[BIT] = 1'b1;
    end
    if (take_z) begin
      tok_nxt.rem_z   = in_tok.rem_z - dvs[PW-1:0];
      tok_nxt.qz[BIT] = 1'b1;
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_tok   = tok_r;

endmodule
`default_nettype wire

// ===== sv/cpp_back.sv =====
`default_nettype none
module cpp_back import cpp_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [RW-1:0] half_length,
  input  wire logic [RW-1:0] radius,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpp_tok_t      in_tok,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cpp_out_t           out_word
);

  logic          v_r;
  cpp_out_t      word_r;
  cpp_out_t      word_nxt;
  logic [CW-1:0] n, hl_w, rad_w, sy, sz;
  logic [CW:0]   qy1, qz1;
  logic [PW:0]   n_w;
  logic          rnd_y, rnd_z, cap, n_zero;

  assign n      = in_tok.root;
  assign n_w    = (PW+1)'(n);
  assign hl_w   = {1'b0, half_length};
  assign rad_w  = {1'b0, radius};
  assign n_zero = n == '0;

  assign rnd_y = ({1'b0, in_tok.rem_y} <= n_w) && ({in_tok.rem_y, 1'b0} >= n_w);
  assign rnd_z = ({1'b0, in_tok.rem_z} <= n_w) && ({in_tok.rem_z, 1'b0} >= n_w);
  assign qy1   = {1'b0, in_tok.qy} + (CW+1)'(rnd_y);
  assign qz1   = {1'b0, in_tok.qz} + (CW+1)'(rnd_z);
  assign sy    = (qy1 > {1'b0, rad_w}) ? rad_w : qy1[CW-1:0];
  assign sz    = (qz1 > {1'b0, rad_w}) ? rad_w : qz1[CW-1:0];
  assign cap   = (hl_w - in_tok.xm) < (rad_w - n);

  always_comb begin
    word_nxt.inside_flag = in_tok.in_x && in_tok.in_yz;
    word_nxt.proj_x      = in_tok.raw_x;
    word_nxt.proj_y      = in_tok.raw_y;
    word_nxt.proj_z      = in_tok.raw_z;
    if (!in_tok.in_x) begin
      word_nxt.proj_x = encode(in_tok.x_neg, hl_w);
    end
    if (!in_tok.in_yz) begin
      word_nxt.proj_y = encode(in_tok.y_neg, sy);
      word_nxt.proj_z = encode(in_tok.z_neg, sz);
    end else if (in_tok.in_x) begin
      if (cap) begin
        word_nxt.proj_x = encode(in_tok.x_neg || (in_tok.xm == '0), hl_w);
      end else if (n_zero) begin
        word_nxt.proj_y = rad_w;
        word_nxt.proj_z = '0;
      end else begin
        word_nxt.proj_y = encode(in_tok.y_neg, sy);
        word_nxt.proj_z = encode(in_tok.z_neg, sz);
      end
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule
`default_nettype wire

// ===== sv/cylinder_point_projection.sv =====
`default_nettype none
// Projects a signed Q16.16 point onto the surface of a capped cylinder lying
// along x, and flags whether the point was inside. One point is taken per
// cycle unless the output stalls. Magnitudes, squares and products are formed
// in the front registers, then come 32 square-root cells (one root bit each),
// 32 division cells (one quotient bit for y and z each), and one rounding and
// selection stage that is also the output register. Each cell has its own
// valid and ready, so a stall on the output only halts cells that hold words
// and bubbles close up. The user must write half_length and radius through
// the cfg port only while no word is in flight; the block does not check it.
`include "cylinder_point_projection_defines.svh"
module cylinder_point_projection import cpp_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [RW-1:0] cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpp_in_t       in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cpp_out_t           out_data
);

  localparam int NCELL = 2 * CW;

  logic [RW-1:0] hl_r, rad_r;

  cpp_tok_t ch_tok [NCELL+1];
  logic     ch_v   [NCELL+1];
  logic     ch_rdy [NCELL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r  <= HALF_LENGTH_RST;
      rad_r <= RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_LENGTH: hl_r  <= cfg_data;
        REG_RADIUS:      rad_r <= cfg_data;
        default:         hl_r  <= hl_r;
      endcase
    end
  end

  cpp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .half_length(hl_r),
    .radius     (rad_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_data),
    .out_valid  (ch_v[0]),
    .out_ready  (ch_rdy[0]),
    .out_tok    (ch_tok[0])
  );

  genvar i;
  for (i = 0; i < NCELL; i++) begin : g_cell
    if (i < CW) begin : g_sqrt
      cpp_sqrt_cell #(.BIT(CW - 1 - i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ch_v[i]),
        .in_ready (ch_rdy[i]),
        .in_tok   (ch_tok[i]),
        .out_valid(ch_v[i+1]),
        .out_ready(ch_rdy[i+1]),
        .out_tok  (ch_tok[i+1])
      );
    end else begin : g_div
      cpp_div_cell #(.BIT(NCELL - 1 - i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ch_v[i]),
        .in_ready (ch_rdy[i]),
        .in_tok   (ch_tok[i]),
        .out_valid(ch_v[i+1]),
        .out_ready(ch_rdy[i+1]),
        .out_tok  (ch_tok[i+1])
      );
    end
  end

  cpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .half_length(hl_r),
    .radius     (rad_r),
    .in_valid   (ch_v[NCELL]),
    .in_ready   (ch_rdy[NCELL]),
    .in_tok     (ch_tok[NCELL]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_data)
  );

  logic [CW-1:0] mag_px, mag_py, mag_pz;

  assign mag_px = mag_of(out_data.proj_x);
  assign mag_py = mag_of(out_data.proj_y);
  assign mag_pz = mag_of(out_data.proj_z);

  `CPP_ASSERT_NOW(a_x_bounded, out_valid, mag_px <= {1'b0, hl_r})
  `CPP_ASSERT_NOW(a_yz_bounded, out_valid, (mag_py <= {1'b0, rad_r}) && (mag_pz <= {1'b0, rad_r}))
  `CPP_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule
`default_nettype wire
